@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the quad cell weight RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset.
`define QCW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("qcw assertion failed");

// Check on every rising edge, reset included.
`define QCW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("qcw assertion failed");

`endif

@@ rtl/core/qcw_pkg.sv @@
// Types, widths and helpers for the quad cell center and weight unit.
// No dependencies; compiled first.
package qcw_pkg;

  localparam int unsigned NODES   = 4;
  localparam int unsigned COORD_W = 24;
  localparam int unsigned SUM_W   = 26;   // sum of four coordinates
  localparam int unsigned DIFF_W  = 27;   // 4*corner - sum, signed
  localparam int unsigned MAG_W   = 26;   // magnitude of that difference
  localparam int unsigned SQ_W    = 52;
  localparam int unsigned DIST_W  = 53;   // squared distance, scaled by 16
  localparam int unsigned PAIR_W  = 2 * DIST_W;
  localparam int unsigned PROD_W  = 3 * DIST_W;
  localparam int unsigned TOT_W   = PROD_W + 2;
  localparam int unsigned WGT_W   = 17;
  localparam int unsigned QBITS   = 18;
  localparam int unsigned NUM_W   = TOT_W + QBITS + 1;
  localparam int unsigned LIMB_W  = 27;   // multiplier partial product operand
  localparam int unsigned ONE_Q16 = 65536;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic [DIST_W-1:0]         dist_t;
  typedef logic [WGT_W-1:0]          wgt_t;

  typedef struct packed {
    coord_t center_z;
    coord_t center_r;
    wgt_t   weight0;
    wgt_t   weight1;
    wgt_t   weight2;
    wgt_t   weight3;
    logic   degenerate;
  } res_t;

  // Equal share of one for k coinciding corners, rounded to nearest.
  function automatic wgt_t share_q16(input logic [2:0] k);
    unique case (k)
      3'd1:    return wgt_t'(ONE_Q16);
      3'd2:    return wgt_t'(ONE_Q16 / 2);
      3'd3:    return wgt_t'((2 * ONE_Q16 + 3) / 6);
      3'd4:    return wgt_t'(ONE_Q16 / 4);
      default: return '0;
    endcase
  endfunction

endpackage

@@ rtl/core/qcw_if.sv @@
// Valid/ready channel interfaces for the cell corner input and result output.
// Depends on qcw_pkg.
interface qcw_in_if;
  import qcw_pkg::*;
  logic   valid;
  logic   ready;
  coord_t corner0_z;
  coord_t corner0_r;
  coord_t corner1_z;
  coord_t corner1_r;
  coord_t corner2_z;
  coord_t corner2_r;
  coord_t corner3_z;
  coord_t corner3_r;
  modport source (output valid, corner0_z, corner0_r, corner1_z, corner1_r,
                  corner2_z, corner2_r, corner3_z, corner3_r, input ready);
  modport sink (input valid, corner0_z, corner0_r, corner1_z, corner1_r,
                corner2_z, corner2_r, corner3_z, corner3_r, output ready);
endinterface

interface qcw_out_if;
  import qcw_pkg::*;
  logic   valid;
  logic   ready;
  coord_t center_z;
  coord_t center_r;
  wgt_t   weight0;
  wgt_t   weight1;
  wgt_t   weight2;
  wgt_t   weight3;
  logic   degenerate;
  modport source (output valid, center_z, center_r, weight0, weight1, weight2,
                  weight3, degenerate, input ready);
  modport sink (input valid, center_z, center_r, weight0, weight1, weight2,
                weight3, degenerate, output ready);
endinterface

@@ rtl/core/qcw_dist_lane.sv @@
// One corner lane: scaled squared distance of a corner to the cell mean.
// Depends on qcw_pkg. Three register stages, all advanced by en_i.
module qcw_dist_lane (
  input  logic           clk_i,
  input  logic           en_i,
  input  qcw_pkg::coord_t z_i,
  input  qcw_pkg::coord_t r_i,
  input  qcw_pkg::sum_t   sz_i,
  input  qcw_pkg::sum_t   sr_i,
  output qcw_pkg::dist_t  d_o,
  output logic            zero_o
);
  import qcw_pkg::*;

  logic [DIFF_W-1:0] dz, dr;
  logic [MAG_W-1:0]  uz_d, ur_d, uz_q, ur_q;
  logic [SQ_W-1:0]   sqz_d, sqr_d, sqz_q, sqr_q;
  dist_t             d_d, d_q;
  logic              zero_q;

  // 4*corner - sum never overflows 27 bits
  assign dz   = {z_i[COORD_W-1], z_i, 2'b00} - {sz_i[SUM_W-1], sz_i};
  assign dr   = {r_i[COORD_W-1], r_i, 2'b00} - {sr_i[SUM_W-1], sr_i};
  assign uz_d = dz[DIFF_W-1] ? MAG_W'(-dz) : dz[MAG_W-1:0];
  assign ur_d = dr[DIFF_W-1] ? MAG_W'(-dr) : dr[MAG_W-1:0];

  assign sqz_d = uz_q * uz_q;
  assign sqr_d = ur_q * ur_q;
  assign d_d   = DIST_W'(sqz_q) + DIST_W'(sqr_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      uz_q   <= uz_d;
      ur_q   <= ur_d;
      sqz_q  <= sqz_d;
      sqr_q  <= sqr_d;
      d_q    <= d_d;
      zero_q <= (d_d == '0);
    end
  end

  assign d_o    = d_q;
  assign zero_o = zero_q;

endmodule

@@ rtl/core/qcw_mul.sv @@
// Two-stage unsigned multiplier built from 27x27 partial products.
// Depends on qcw_pkg for the limb width.
module qcw_mul #(
  parameter int unsigned A_W = 53,
  parameter int unsigned B_W = 53
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic [A_W+B_W-1:0] p_o
);
  import qcw_pkg::*;

  localparam int unsigned NA  = (A_W + LIMB_W - 1) / LIMB_W;
  localparam int unsigned NB  = (B_W + LIMB_W - 1) / LIMB_W;
  localparam int unsigned P_W = A_W + B_W;

  logic [NA*LIMB_W-1:0] a_ext;
  logic [NB*LIMB_W-1:0] b_ext;
  logic [2*LIMB_W-1:0]  pp_q [NA][NB];
  logic [P_W-1:0]       acc;
  logic [P_W-1:0]       p_q;

  assign a_ext = (NA*LIMB_W)'(a_i);
  assign b_ext = (NB*LIMB_W)'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= a_ext[i*LIMB_W +: LIMB_W] * b_ext[j*LIMB_W +: LIMB_W];
        end
      end
    end
  end

  // merge the shifted partial products
  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (P_W'(pp_q[i][j]) << (LIMB_W * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= acc;
    end
  end

  assign p_o = p_q;

endmodule

@@ rtl/core/qcw_div_lane.sv @@
// Pipelined restoring divider: one quotient bit per stage, QBITS stages.
// Depends on qcw_pkg. Gives floor(num / (2*den)) for num below 2^QBITS*2*den.
module qcw_div_lane (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [qcw_pkg::NUM_W-1:0] num_i,
  input  logic [qcw_pkg::TOT_W-1:0] den_i,
  output qcw_pkg::wgt_t             q_o
);
  import qcw_pkg::*;

  logic [NUM_W-1:0] rem_q [QBITS];
  logic [TOT_W-1:0] den_q [QBITS];
  logic [QBITS-1:0] quo_q [QBITS];
  logic [NUM_W-1:0] rem_in [QBITS];
  logic [TOT_W-1:0] den_in [QBITS];
  logic [QBITS-1:0] quo_in [QBITS];
  logic [NUM_W-1:0] trial [QBITS];
  logic [NUM_W-1:0] rem_d [QBITS];
  logic [QBITS-1:0] quo_d [QBITS];

  // stage k decides quotient bit QBITS-1-k
  always_comb begin
    for (int k = 0; k < QBITS; k++) begin
      if (k == 0) begin
        rem_in[k] = num_i;
        den_in[k] = den_i;
        quo_in[k] = '0;
      end else begin
        rem_in[k] = rem_q[k-1];
        den_in[k] = den_q[k-1];
        quo_in[k] = quo_q[k-1];
      end
      trial[k] = NUM_W'(den_in[k]) << (QBITS - k);
      if (rem_in[k] >= trial[k]) begin
        rem_d[k] = rem_in[k] - trial[k];
        quo_d[k] = {quo_in[k][QBITS-2:0], 1'b1};
      end else begin
        rem_d[k] = rem_in[k];
        quo_d[k] = {quo_in[k][QBITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QBITS; k++) begin
        rem_q[k] <= rem_d[k];
        den_q[k] <= den_in[k];
        quo_q[k] <= quo_d[k];
      end
    end
  end

  assign q_o = quo_q[QBITS-1][WGT_W-1:0];

endmodule

@@ rtl/core/quad_center_idw_weights_unit.sv @@
// Top level of the quad cell center and inverse-distance-squared weight unit.
// Depends on qcw_pkg, qcw_if, qcw_dist_lane, qcw_mul, qcw_div_lane and
// assert_macros.svh.
//
// Usage:
//   in_i carries one transaction per cell: the (z, r) of its four corners.
//   out_o returns one transaction per cell, in order: the floored mean of the
//   corners and four weights in unsigned 1.16, each rounded to nearest. When
//   a corner sits exactly on the mean, the coinciding corners share one
//   equally, the rest get zero and degenerate is raised.
//   Throughput is one cell per cycle while the pipeline is not held. The
//   depth is set by the 18-stage divider in each corner lane, two layers of
//   2-stage wide multipliers and the distance lanes.
//   The pipeline advances as one; a 2-entry output queue sits behind it, so
//   the input keeps being taken while one finished result waits. When the
//   queue is full and out_o.ready is low the whole pipeline holds and
//   in_i.ready drops; nothing in flight is lost.
//   Reset clears all valid flags and the queue; no item is held across it.
`include "assert_macros.svh"

module quad_center_idw_weights_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  qcw_in_if.sink    in_i,
  qcw_out_if.source out_o
);
  import qcw_pkg::*;

  localparam int unsigned LAT       = 29;        // register stages before the queue
  localparam int unsigned CEN_DEPTH = LAT - 2;
  localparam int unsigned ZDEPTH    = LAT - 5;

  logic           adv;
  logic [LAT-1:0] v_q;

  // stage 1: corners
  coord_t z1_q [NODES];
  coord_t r1_q [NODES];
  // stage 2: sums and corners
  coord_t z2_q [NODES];
  coord_t r2_q [NODES];
  sum_t   sz_q, sr_q;
  // distance lanes (stage 5) and their delays
  dist_t            d5 [NODES];
  logic [NODES-1:0] zero5;
  dist_t            d6_q [NODES];
  dist_t            d7_q [NODES];
  // products
  logic [PAIR_W-1:0] d01, d23;
  logic [PROD_W-1:0] p9 [NODES];
  logic [PROD_W-1:0] p10_q [NODES];
  logic [TOT_W-1:0]  s10_q, s11_q;
  logic [NUM_W-1:0]  num11_q [NODES];
  wgt_t              q29 [NODES];
  // side band
  logic [2*COORD_W-1:0] cen_q [CEN_DEPTH];
  logic [NODES-1:0]     zl_q [ZDEPTH];
  // output queue
  res_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  res_t       res;
  logic       push, pop;
  logic [NODES-1:0] zf;
  wgt_t       share;

  // advance unless the queue is full and not draining
  assign adv        = (cnt_q != 2'd2) || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[LAT-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      z1_q[0] <= in_i.corner0_z;
      r1_q[0] <= in_i.corner0_r;
      z1_q[1] <= in_i.corner1_z;
      r1_q[1] <= in_i.corner1_r;
      z1_q[2] <= in_i.corner2_z;
      r1_q[2] <= in_i.corner2_r;
      z1_q[3] <= in_i.corner3_z;
      r1_q[3] <= in_i.corner3_r;
      z2_q    <= z1_q;
      r2_q    <= r1_q;
      sz_q    <= SUM_W'(z1_q[0]) + SUM_W'(z1_q[1]) + SUM_W'(z1_q[2]) + SUM_W'(z1_q[3]);
      sr_q    <= SUM_W'(r1_q[0]) + SUM_W'(r1_q[1]) + SUM_W'(r1_q[2]) + SUM_W'(r1_q[3]);
    end
  end

  // one distance lane per corner
  for (genvar j = 0; j < NODES; j++) begin : g_dist
    qcw_dist_lane u_dist (
      .clk_i  (clk_i),
      .en_i   (adv),
      .z_i    (z2_q[j]),
      .r_i    (r2_q[j]),
      .sz_i   (sz_q),
      .sr_i   (sr_q),
      .d_o    (d5[j]),
      .zero_o (zero5[j])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d6_q <= d5;
      d7_q <= d6_q;
    end
  end

  // pair products, then the product of the other three distances per corner
  qcw_mul #(.A_W(DIST_W), .B_W(DIST_W)) u_mul01 (
    .clk_i (clk_i), .en_i (adv), .a_i (d5[0]), .b_i (d5[1]), .p_o (d01)
  );
  qcw_mul #(.A_W(DIST_W), .B_W(DIST_W)) u_mul23 (
    .clk_i (clk_i), .en_i (adv), .a_i (d5[2]), .b_i (d5[3]), .p_o (d23)
  );
  qcw_mul #(.A_W(PAIR_W), .B_W(DIST_W)) u_mul_p0 (
    .clk_i (clk_i), .en_i (adv), .a_i (d23), .b_i (d7_q[1]), .p_o (p9[0])
  );
  qcw_mul #(.A_W(PAIR_W), .B_W(DIST_W)) u_mul_p1 (
    .clk_i (clk_i), .en_i (adv), .a_i (d23), .b_i (d7_q[0]), .p_o (p9[1])
  );
  qcw_mul #(.A_W(PAIR_W), .B_W(DIST_W)) u_mul_p2 (
    .clk_i (clk_i), .en_i (adv), .a_i (d01), .b_i (d7_q[3]), .p_o (p9[2])
  );
  qcw_mul #(.A_W(PAIR_W), .B_W(DIST_W)) u_mul_p3 (
    .clk_i (clk_i), .en_i (adv), .a_i (d01), .b_i (d7_q[2]), .p_o (p9[3])
  );

  // merge: total of the products, then the rounding numerators
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p10_q <= p9;
      s10_q <= TOT_W'(p9[0]) + TOT_W'(p9[1]) + TOT_W'(p9[2]) + TOT_W'(p9[3]);
      s11_q <= s10_q;
      for (int j = 0; j < NODES; j++) begin
        num11_q[j] <= (NUM_W'(p10_q[j]) << (QBITS - 1)) + NUM_W'(s10_q);
      end
    end
  end

  for (genvar j = 0; j < NODES; j++) begin : g_div
    qcw_div_lane u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (num11_q[j]),
      .den_i (s11_q),
      .q_o   (q29[j])
    );
  end

  // carry center and coincidence flags alongside
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cen_q[0] <= {sz_q[SUM_W-1:2], sr_q[SUM_W-1:2]};
      for (int k = 1; k < CEN_DEPTH; k++) begin
        cen_q[k] <= cen_q[k-1];
      end
      zl_q[0] <= zero5;
      for (int k = 1; k < ZDEPTH; k++) begin
        zl_q[k] <= zl_q[k-1];
      end
    end
  end

  assign zf    = zl_q[ZDEPTH-1];
  assign share = share_q16(3'($countones(zf)));

  always_comb begin
    res.center_z   = cen_q[CEN_DEPTH-1][2*COORD_W-1:COORD_W];
    res.center_r   = cen_q[CEN_DEPTH-1][COORD_W-1:0];
    res.degenerate = |zf;
    if (|zf) begin
      res.weight0 = zf[0] ? share : '0;
      res.weight1 = zf[1] ? share : '0;
      res.weight2 = zf[2] ? share : '0;
      res.weight3 = zf[3] ? share : '0;
    end else begin
      res.weight0 = q29[0];
      res.weight1 = q29[1];
      res.weight2 = q29[2];
      res.weight3 = q29[3];
    end
  end

  // output queue
  assign push = adv && v_q[LAT-1];
  assign pop  = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  assign out_o.valid      = (cnt_q != 2'd0);
  assign out_o.center_z   = fifo_q[rd_ptr_q].center_z;
  assign out_o.center_r   = fifo_q[rd_ptr_q].center_r;
  assign out_o.weight0    = fifo_q[rd_ptr_q].weight0;
  assign out_o.weight1    = fifo_q[rd_ptr_q].weight1;
  assign out_o.weight2    = fifo_q[rd_ptr_q].weight2;
  assign out_o.weight3    = fifo_q[rd_ptr_q].weight3;
  assign out_o.degenerate = fifo_q[rd_ptr_q].degenerate;

  `QCW_ASSERT_ALWAYS(a_cnt_bound, clk_i, cnt_q <= 2'd2)
  `QCW_ASSERT(a_hold_on_stall, clk_i, rst_ni, !adv |=> $stable(v_q))
  `QCW_ASSERT(a_weight_range, clk_i, rst_ni, out_o.valid |-> (out_o.weight0 <= wgt_t'(ONE_Q16)) && (out_o.weight1 <= wgt_t'(ONE_Q16)) && (out_o.weight2 <= wgt_t'(ONE_Q16)) && (out_o.weight3 <= wgt_t'(ONE_Q16)))
  `QCW_ASSERT(a_degen_share, clk_i, rst_ni, (out_o.valid && out_o.degenerate) |-> ((out_o.weight0 != '0) || (out_o.weight1 != '0) || (out_o.weight2 != '0) || (out_o.weight3 != '0)))

endmodule
